// File: design/nir_pkg.sv
// Package for the NEC IR pulse decoder: payload structs, register indexes,
// reset values and widths. No dependencies.
package nir_pkg;

    localparam int DUR_W  = 16;
    localparam int TOL_W  = 7;
    localparam int SPAN_W = DUR_W + TOL_W;
    localparam int CODE_W = 32;
    localparam int CNT_W  = 6;
    localparam int IDX_W  = 3;

    localparam logic [CNT_W-1:0] MAX_BITS = CNT_W'(32);

    localparam logic [DUR_W-1:0] LEAD_MARK_RST  = DUR_W'(9000);
    localparam logic [DUR_W-1:0] LEAD_SPACE_RST = DUR_W'(4500);
    localparam logic [DUR_W-1:0] BIT_MARK_RST   = DUR_W'(560);
    localparam logic [TOL_W-1:0] TOL_RST        = TOL_W'(25);
    localparam logic [DUR_W-1:0] BIT_SPLIT_RST  = DUR_W'(1000);

    // Expected times of 2 or less always pass.
    localparam logic [DUR_W-1:0] WANT_FREE_MAX  = DUR_W'(2);

    typedef enum logic [IDX_W-1:0] {
        REG_LEAD_MARK  = 3'd0,
        REG_LEAD_SPACE = 3'd1,
        REG_BIT_MARK   = 3'd2,
        REG_TOLERANCE  = 3'd3,
        REG_BIT_SPLIT  = 3'd4
    } t_reg_idx;

    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic             pulse_level;
        logic [DUR_W-1:0] duration_us;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [CNT_W-1:0]  bit_count;
        logic              overflow;
    } t_out;

endpackage

// File: design/nir_win.sv
// Tolerance window check for one phase duration.
// Uses nir_pkg; span is expected time times tolerance percent, precomputed.
module nir_win (
    input  logic [nir_pkg::DUR_W-1:0]  i_got,
    input  logic [nir_pkg::DUR_W-1:0]  i_want,
    input  logic [nir_pkg::SPAN_W-1:0] i_span,
    output logic                       o_pass
);
    import nir_pkg::*;

    logic             got_ge;
    logic [DUR_W-1:0] diff;
    logic [SPAN_W-1:0] diff_x100;
    logic [SPAN_W-1:0] span_up;

    // got >= want - ceil(span/100)  <=>  100*(want-got) <= span + 99
    // got <= want + floor(span/100) <=>  100*(got-want) <= span
    always_comb begin
        got_ge    = (i_got >= i_want);
        diff      = got_ge ? (i_got - i_want) : (i_want - i_got);
        diff_x100 = (SPAN_W'(diff) << 6) + (SPAN_W'(diff) << 5) + (SPAN_W'(diff) << 2);
        span_up   = i_span + SPAN_W'(99);
        if (i_want <= WANT_FREE_MAX) begin
            o_pass = 1'b1;
        end else if (got_ge) begin
            o_pass = (diff_x100 <= i_span);
        end else begin
            o_pass = (diff_x100 <= span_up);
        end
    end

endmodule

// File: design/nec_ir_pulse_decoder.sv
// NEC IR pulse-train decoder top level: input register, phase tracker,
// result register and configuration registers. Uses nir_pkg and nir_win.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------
//  in      | i_in_valid, o_in_stall, i_in         | one edge or timeout item
//  out     | o_out_valid, i_out_stall, o_out      | one decoded frame item
//  cfg     | i_cfg_valid, o_cfg_ready, index/data | one register write
//
// One item per cycle while input is not stalled. An item enters the input
// register, and the phase state updates and any result is registered when
// it leaves. After reset and after each register write, input stalls while
// the window spans are recomputed. A stalled result holds, and the input
// register still takes one more item behind it.
module nec_ir_pulse_decoder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  nir_pkg::t_in             i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output nir_pkg::t_out            o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [nir_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [nir_pkg::DUR_W-1:0] i_cfg_data
);
    import nir_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4
    } t_phase;

    localparam logic [1:0] SETTLE_CYC = 2'd2;

    logic [DUR_W-1:0]  r_lead_mark, r_lead_space, r_bit_mark, r_bit_split;
    logic [TOL_W-1:0]  r_tol;
    logic [SPAN_W-1:0] r_lm_span, r_ls_span, r_bm_span;
    logic [1:0]        r_settle;

    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_bits, n_bits;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_ovf, n_ovf;

    logic              cfg_we;
    logic              out_free;
    logic              proceed;
    logic              emit;
    logic [DUR_W-1:0]  want;
    logic [SPAN_W-1:0] span;
    logic              pass;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign proceed     = r_in_valid && out_free;
    assign o_in_stall  = (r_settle != 2'd0) || (r_in_valid && !proceed);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_mark  <= LEAD_MARK_RST;
            r_lead_space <= LEAD_SPACE_RST;
            r_bit_mark   <= BIT_MARK_RST;
            r_tol        <= TOL_RST;
            r_bit_split  <= BIT_SPLIT_RST;
            r_settle     <= SETTLE_CYC;
        end else begin
            if (cfg_we) begin
                r_settle <= SETTLE_CYC;
                unique case (i_cfg_index)
                    REG_LEAD_MARK:  r_lead_mark  <= i_cfg_data;
                    REG_LEAD_SPACE: r_lead_space <= i_cfg_data;
                    REG_BIT_MARK:   r_bit_mark   <= i_cfg_data;
                    REG_TOLERANCE:  r_tol        <= i_cfg_data[TOL_W-1:0];
                    REG_BIT_SPLIT:  r_bit_split  <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // Window spans: expected time times tolerance percent.
    always_ff @(posedge i_clk) begin
        r_lm_span <= SPAN_W'(r_lead_mark)  * SPAN_W'(r_tol);
        r_ls_span <= SPAN_W'(r_lead_space) * SPAN_W'(r_tol);
        r_bm_span <= SPAN_W'(r_bit_mark)   * SPAN_W'(r_tol);
    end

    always_comb begin
        unique case (r_phase)
            PH_LEAD_MARK: begin
                want = r_lead_mark;
                span = r_lm_span;
            end
            PH_LEAD_SPACE: begin
                want = r_lead_space;
                span = r_ls_span;
            end
            PH_BIT_MARK: begin
                want = r_bit_mark;
                span = r_bm_span;
            end
            default: begin
                want = '0;
                span = '0;
            end
        endcase
    end

    nir_win u_win (
        .i_got  (r_in.duration_us),
        .i_want (want),
        .i_span (span),
        .o_pass (pass)
    );

    always_comb begin
        n_phase = r_phase;
        n_bits  = r_bits;
        n_code  = r_code;
        n_ovf   = r_ovf;
        emit    = 1'b0;
        if (r_in.cmd == CMD_TIMEOUT) begin
            if (r_phase != PH_IDLE) begin
                emit    = 1'b1;
                n_phase = PH_IDLE;
                n_bits  = '0;
                n_code  = '0;
                n_ovf   = 1'b0;
            end
        end else if (!pass) begin
            n_phase = PH_IDLE;
            n_bits  = '0;
            n_code  = '0;
            n_ovf   = 1'b0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_in.pulse_level) n_phase = PH_LEAD_MARK;
                end
                PH_LEAD_MARK: begin
                    if (!r_in.pulse_level) n_phase = PH_LEAD_SPACE;
                end
                PH_LEAD_SPACE: begin
                    if (r_in.pulse_level) n_phase = PH_BIT_MARK;
                end
                PH_BIT_MARK: begin
                    if (!r_in.pulse_level) n_phase = PH_BIT_SPACE;
                end
                PH_BIT_SPACE: begin
                    n_phase = PH_BIT_MARK;
                    if (r_bits < MAX_BITS) begin
                        if (r_in.duration_us < r_bit_split) begin
                            n_code[r_bits[$clog2(CODE_W)-1:0]] = 1'b1;
                        end
                        n_bits = r_bits + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_bits  = '0;
                    n_code  = '0;
                    n_ovf   = 1'b0;
                end
            endcase
        end
    end

    // Input register, phase state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_bits      <= '0;
            r_code      <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
                r_in       <= i_in;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end
            if (proceed) begin
                r_phase <= n_phase;
                r_bits  <= n_bits;
                r_code  <= n_code;
                r_ovf   <= n_ovf;
            end
            if (proceed && emit) begin
                r_out_valid     <= 1'b1;
                r_out.code_bits <= r_code;
                r_out.bit_count <= r_bits;
                r_out.overflow  <= r_ovf;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: design/nir_chk.sv
// Port-level checker for nec_ir_pulse_decoder, bound to the top level.
// Uses nir_pkg for the payload types.
module nir_chk (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_in_stall,
    input  logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  nir_pkg::t_out             o_out,
    input  logic                      i_cfg_valid,
    input  logic                      o_cfg_ready
);
    import nir_pkg::*;

    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("item shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled item changed");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.bit_count <= MAX_BITS)
        else $error("bit count above limit");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.overflow |-> o_out.bit_count == MAX_BITS)
        else $error("overflow without full count");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_in_stall)
        else $error("input open right after register write");

endmodule

bind nec_ir_pulse_decoder nir_chk u_nir_chk (.*);

// File: sim/nec_frame_check_pkg.sv
// Frame scoreboard for the NEC IR pulse decoder bench: tracks the decoder
// phase and collected bits per accepted item and checks each emitted frame.
// Depends on nir_pkg.
package nec_frame_check_pkg;
    import nir_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE
    } t_rx_phase;

    class nec_frame_scoreboard;
        logic [DUR_W-1:0]  lead_mark_us;
        logic [DUR_W-1:0]  lead_space_us;
        logic [DUR_W-1:0]  bit_mark_us;
        logic [DUR_W-1:0]  split_us;
        logic [TOL_W-1:0]  tol_pct;

        t_rx_phase         phase;
        logic [CNT_W-1:0]  bits_got;
        logic [CODE_W-1:0] code_acc;
        logic              ovf;

        t_out              frames_q[$];
        int                frames_due;
        int                errors;

        function new();
            lead_mark_us  = LEAD_MARK_RST;
            lead_space_us = LEAD_SPACE_RST;
            bit_mark_us   = BIT_MARK_RST;
            split_us      = BIT_SPLIT_RST;
            tol_pct       = TOL_RST;
            frames_due    = 0;
            errors        = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase    = PH_IDLE;
            bits_got = '0;
            code_acc = '0;
            ovf      = 1'b0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [DUR_W-1:0] data);
            case (idx)
                REG_LEAD_MARK:  lead_mark_us  = data;
                REG_LEAD_SPACE: lead_space_us = data;
                REG_BIT_MARK:   bit_mark_us   = data;
                REG_TOLERANCE:  tol_pct       = data[TOL_W-1:0];
                REG_BIT_SPLIT:  split_us      = data;
                default: ;
            endcase
        endfunction

        // Inclusive acceptance window for a phase of expected length want.
        function void window(input logic [DUR_W-1:0] want,
                             output int unsigned lo, output int unsigned hi);
            int unsigned prod;
            int unsigned down;
            prod = 32'(want) * 32'(tol_pct);
            if (want <= WANT_FREE_MAX) begin
                lo = 0;
                hi = 32'hFFFF_FFFF;
            end else begin
                down = (prod + 99) / 100;
                lo   = (down > 32'(want)) ? 0 : 32'(want) - down;
                hi   = 32'(want) + prod / 100;
            end
        endfunction

        // Returns 0 for a timeout while idle, which the decoder ignores.
        function bit note_item(t_in it);
            logic [DUR_W-1:0] want;
            int unsigned      lo;
            int unsigned      hi;
            t_out             fr;
            if (it.cmd == CMD_TIMEOUT) begin
                if (phase == PH_IDLE)
                    return 1'b0;
                fr.code_bits = code_acc;
                fr.bit_count = bits_got;
                fr.overflow  = ovf;
                frames_q.push_back(fr);
                frames_due++;
                clear_frame();
                return 1'b1;
            end
            case (phase)
                PH_LEAD_MARK:  want = lead_mark_us;
                PH_LEAD_SPACE: want = lead_space_us;
                PH_BIT_MARK:   want = bit_mark_us;
                default:       want = '0;
            endcase
            window(want, lo, hi);
            if (32'(it.duration_us) < lo || 32'(it.duration_us) > hi) begin
                clear_frame();
                return 1'b1;
            end
            case (phase)
                PH_IDLE:       if (it.pulse_level) phase = PH_LEAD_MARK;
                PH_LEAD_MARK:  if (!it.pulse_level) phase = PH_LEAD_SPACE;
                PH_LEAD_SPACE: if (it.pulse_level) phase = PH_BIT_MARK;
                PH_BIT_MARK:   if (!it.pulse_level) phase = PH_BIT_SPACE;
                PH_BIT_SPACE: begin
                    phase = PH_BIT_MARK;
                    if (bits_got < MAX_BITS) begin
                        if (it.duration_us < split_us)
                            code_acc[bits_got[4:0]] = 1'b1;
                        bits_got++;
                    end else begin
                        ovf = 1'b1;
                    end
                end
                default: clear_frame();
            endcase
            return 1'b1;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (frames_q.size() == 0) begin
                report($sformatf("frame with none pending: code=%h count=%0d ovf=%b",
                                 got.code_bits, got.bit_count, got.overflow));
                return;
            end
            want = frames_q.pop_front();
            if (got.code_bits !== want.code_bits)
                report($sformatf("code_bits got %h want %h", got.code_bits, want.code_bits));
            if (got.bit_count !== want.bit_count)
                report($sformatf("bit_count got %0d want %0d", got.bit_count, want.bit_count));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow got %b want %b", got.overflow, want.overflow));
        endtask
    endclass

endpackage

// File: sim/tb_nec_ir_pulse_decoder.sv
// Bench for nec_ir_pulse_decoder: directed and random NEC pulse trains under
// several register settings with random input gaps and output stalls.
// Depends on nir_pkg and nec_frame_check_pkg.
module tb_nec_ir_pulse_decoder;
    import nir_pkg::*;
    import nec_frame_check_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE       = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int PHASE_FRAMES = 3;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in               i_in        = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [DUR_W-1:0]  i_cfg_data  = '0;

    nec_frame_scoreboard sb;
    int                  items_sent  = 0;
    int                  idle_cycles = 0;
    bit                  in_calm     = 1'b0;

    nec_ir_pulse_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int stall_len;
        int free_len;
        forever begin
            stall_len = gap_len();
            free_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 150)
                                                    : $urandom_range(1, 8);
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat (free_len) @(posedge i_clk);
        end
    end

    task automatic send_item(logic cmd, logic lvl, logic [DUR_W-1:0] dur);
        t_in it;
        int  gap;
        it.cmd         = cmd;
        it.pulse_level = lvl;
        it.duration_us = dur;
        gap = in_calm ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (sb.note_item(it))
            items_sent++;
    endtask

    // Phase length near the window of want; rough trains sometimes miss it.
    function automatic logic [DUR_W-1:0] phase_dur(logic [DUR_W-1:0] want, bit rough);
        int unsigned lo;
        int unsigned hi;
        int          r;
        sb.window(want, lo, hi);
        if (hi > 32'hFFFF)
            hi = 32'hFFFF;
        r = $urandom_range(0, 99);
        if (rough && r < 6) begin
            if (lo > 0)
                return DUR_W'(lo - 1);
            else if (hi < 32'hFFFF)
                return DUR_W'(hi + 1);
            return DUR_W'($urandom);
        end
        if (rough && r < 10)
            return DUR_W'($urandom);
        if (r < 25)
            return DUR_W'(lo);
        if (r < 40)
            return DUR_W'(hi);
        return DUR_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [DUR_W-1:0] space_dur(bit one);
        bit edge_pick;
        edge_pick = ($urandom_range(0, 6) == 0);
        if (one && sb.split_us != '0)
            return edge_pick ? sb.split_us - 1'b1
                             : DUR_W'($urandom_range(0, sb.split_us - 1));
        return edge_pick ? sb.split_us : DUR_W'($urandom_range(sb.split_us, 16'hFFFF));
    endfunction

    function automatic logic rough_lvl(logic lvl, bit rough);
        return (rough && $urandom_range(0, 29) == 0) ? ~lvl : lvl;
    endfunction

    task automatic send_frame(int nbits, bit rough);
        send_item(CMD_EDGE, 1'b1, DUR_W'($urandom));
        send_item(CMD_EDGE, rough_lvl(1'b0, rough), phase_dur(sb.lead_mark_us, rough));
        send_item(CMD_EDGE, rough_lvl(1'b1, rough), phase_dur(sb.lead_space_us, rough));
        for (int i = 0; i < nbits; i++) begin
            send_item(CMD_EDGE, rough_lvl(1'b0, rough), phase_dur(sb.bit_mark_us, rough));
            send_item(CMD_EDGE, rough_lvl(1'b1, rough), space_dur(1'($urandom_range(0, 1))));
        end
        send_item(CMD_TIMEOUT, 1'($urandom), DUR_W'($urandom));
    endtask

    task automatic send_noise(int n);
        for (int i = 0; i < n; i++)
            send_item(($urandom_range(0, 3) == 0) ? CMD_TIMEOUT : CMD_EDGE,
                      1'($urandom), DUR_W'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.frames_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DUR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(int p);
        logic [DUR_W-1:0] lm;
        logic [DUR_W-1:0] ls;
        logic [DUR_W-1:0] bm;
        logic [DUR_W-1:0] sp;
        logic [TOL_W-1:0] tol;
        lm  = DUR_W'($urandom_range(3, 20000));
        ls  = DUR_W'($urandom_range(3, 10000));
        bm  = DUR_W'($urandom_range(3, 3000));
        sp  = DUR_W'($urandom_range(0, 4000));
        tol = TOL_W'($urandom_range(0, 60));
        case (p)
            1: tol = '0;
            2: begin
                lm  = '1;
                ls  = '1;
                bm  = '1;
                sp  = '1;
                tol = TOL_W'(100);
            end
            3: begin
                lm  = DUR_W'(0);
                ls  = DUR_W'(1);
                bm  = WANT_FREE_MAX;
                sp  = '0;
                tol = '1;
            end
            4: begin
                lm  = DUR_W'($urandom);
                ls  = DUR_W'($urandom);
                bm  = DUR_W'($urandom);
                sp  = DUR_W'($urandom);
                tol = TOL_W'($urandom_range(101, 127));
            end
            5: begin
                lm = WANT_FREE_MAX + 1'b1;
                ls = WANT_FREE_MAX + 1'b1;
                bm = WANT_FREE_MAX + 1'b1;
            end
            default: ;
        endcase
        write_reg(REG_LEAD_MARK, lm);
        write_reg(REG_LEAD_SPACE, ls);
        write_reg(REG_BIT_MARK, bm);
        write_reg(REG_TOLERANCE, DUR_W'(tol));
        write_reg(REG_BIT_SPLIT, sp);
        write_reg(IDX_W'($urandom_range(int'(REG_BIT_SPLIT) + 1, (1 << IDX_W) - 1)),
                  DUR_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_items();
        int unsigned lm_lo, lm_hi, ls_lo, ls_hi, bm_lo, bm_hi;
        sb.window(sb.lead_mark_us, lm_lo, lm_hi);
        sb.window(sb.lead_space_us, ls_lo, ls_hi);
        sb.window(sb.bit_mark_us, bm_lo, bm_hi);
        send_item(CMD_TIMEOUT, 1'b1, '1);
        send_item(CMD_EDGE, 1'b0, '0);
        send_item(CMD_EDGE, 1'b1, '1);
        send_item(CMD_EDGE, 1'b1, DUR_W'(lm_lo));
        send_item(CMD_EDGE, 1'b0, DUR_W'(lm_hi));
        send_item(CMD_EDGE, 1'b1, DUR_W'(ls_lo));
        send_item(CMD_EDGE, 1'b0, DUR_W'(bm_lo));
        send_item(CMD_EDGE, 1'b1, '0);
        send_item(CMD_EDGE, 1'b0, DUR_W'(bm_hi));
        send_item(CMD_EDGE, 1'b1, sb.split_us - 1'b1);
        send_item(CMD_EDGE, 1'b0, sb.bit_mark_us);
        send_item(CMD_EDGE, 1'b1, sb.split_us);
        send_item(CMD_EDGE, 1'b0, sb.bit_mark_us);
        send_item(CMD_EDGE, 1'b1, '1);
        send_item(CMD_EDGE, 1'b1, sb.bit_mark_us);
        send_item(CMD_TIMEOUT, 1'b0, '0);
        send_item(CMD_EDGE, 1'b1, DUR_W'(1));
        send_item(CMD_EDGE, 1'b0, DUR_W'(lm_hi + 1));
        send_item(CMD_TIMEOUT, 1'b0, '0);
        send_item(CMD_EDGE, 1'b1, DUR_W'(1));
        send_item(CMD_EDGE, 1'b0, DUR_W'(lm_lo - 1));
        send_item(CMD_EDGE, 1'b1, '0);
        send_item(CMD_EDGE, 1'b0, sb.lead_mark_us);
        send_item(CMD_EDGE, 1'b1, DUR_W'(ls_hi + 1));
        send_item(CMD_EDGE, 1'b1, DUR_W'(2));
        send_item(CMD_TIMEOUT, 1'b1, '1);
    endtask

    initial begin
        int items0;
        int frames0;
        int r;
        int nbits;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_items();
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                configure(p);
            end
            items0  = items_sent;
            frames0 = sb.frames_due;
            while (items_sent - items0 < PHASE_ITEMS ||
                   sb.frames_due - frames0 < PHASE_FRAMES) begin
                in_calm = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    send_noise($urandom_range(1, 5));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        nbits = 32;
                    else if (r < 40)
                        nbits = $urandom_range(33, 40);
                    else
                        nbits = $urandom_range(0, 31);
                    send_frame(nbits, $urandom_range(0, 3) == 0);
                end
            end
        end
        drain();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
